// ===== hdl/bscfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bscfd_pkg
// Shared types, constants and helpers of the bit string first difference
// comparator.
// ----------------------------------------------------------------------------
package bscfd_pkg;

  // Longest string in bytes
  localparam int unsigned MaxBytes = 256;

  localparam int unsigned IdxW = 9;
  localparam int unsigned PosW = 12;

  // Saturation bounds for byte index and reported position
  localparam logic [IdxW-1:0] IdxCap = IdxW'((MaxBytes > 511) ? 511 : MaxBytes);
  localparam logic [PosW-1:0] PosCap = PosW'((MaxBytes * 8 > 4095) ? 4095 : MaxBytes * 8);

  // Ordering codes
  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LESS    = 2'd1,
    ORD_GREATER = 2'd2
  } order_e;

  // One byte pair as held in the input register
  typedef struct packed {
    logic [7:0] a_byte;
    logic [3:0] a_valid;
    logic [7:0] b_byte;
    logic [3:0] b_valid;
    logic       last;
  } item_t;

  // Outcome of comparing one byte pair
  typedef struct packed {
    logic          fix;      // verdict settles on this pair
    order_e        order;
    logic [PosW:0] pos;      // unsaturated position, one spare bit
  } step_t;

  // Mask of the m leading bits of a byte (m in 0..8)
  function automatic logic [7:0] lead_mask(input logic [3:0] m);
    logic [7:0] full;
    full = 8'hFF;
    return full << (4'd8 - m);
  endfunction

  // Clamp a valid count to 8
  function automatic logic [3:0] clamp8(input logic [3:0] v);
    return (v > 4'd8) ? 4'd8 : v;
  endfunction

  // Saturate a position to the bound
  function automatic logic [PosW-1:0] sat_pos(input logic [PosW:0] p);
    return (p > {1'b0, PosCap}) ? PosCap : p[PosW-1:0];
  endfunction

endpackage

// ===== hdl/bscfd_if.sv =====
// ----------------------------------------------------------------------------
// bscfd_in_if / bscfd_out_if
// Valid/ready channels for byte pairs in and verdict words out.
// ----------------------------------------------------------------------------
interface bscfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] a_byte;
  logic [3:0] a_valid;
  logic [7:0] b_byte;
  logic [3:0] b_valid;
  logic       last;

  modport source (output valid, a_byte, a_valid, b_byte, b_valid, last, input ready);
  modport sink   (input valid, a_byte, a_valid, b_byte, b_valid, last, output ready);
endinterface

interface bscfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  order;
  logic [11:0] diff_pos;

  modport source (output valid, order, diff_pos, input ready);
  modport sink   (input valid, order, diff_pos, output ready);
endinterface

// ===== hdl/bit_string_compare_first_difference.sv =====
// ----------------------------------------------------------------------------
// bit_string_compare_first_difference
// Streams two MSB-first bit strings a byte pair per word and reports the
// order of the strings and the position of their first difference.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one byte of each string with its count of valid leading
//   bits (a count below 8 ends that string) and a last mark. One verdict
//   word leaves on out_o for each word marked last: order (0 equal, 1 first
//   string less, 2 first string greater) and diff_pos, the first differing
//   bit or the shorter length. Words after the verdict is fixed are dropped
//   until last.
//   Throughput: one word per cycle while out_o is not stalled. A last word
//   is registered in the input register on acceptance; its verdict passes
//   the byte compare into the result register, which drives out_o.
//   Reset clears the comparison state and empties both registers.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one pending word; in_i.ready then drops.
// ----------------------------------------------------------------------------
module bit_string_compare_first_difference
  import bscfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bscfd_in_if.sink    in_i,
  bscfd_out_if.source out_o
);

  logic            s1_valid_q, s1_valid_d;
  item_t           s1_item_q;
  logic            adv, fire;

  logic [IdxW-1:0] byte_index_q, byte_index_d, idx_n;
  logic            decided_q, decided_d, dec_n;
  order_e          order_q, order_d, ord_n;
  logic [PosW-1:0] pos_q, pos_d, pos_n;

  step_t           step;

  // Input register advances when it is empty or the result side has room
  assign in_i.ready = !s1_valid_q || adv;
  assign fire       = s1_valid_q && adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q.a_byte  <= in_i.a_byte;
      s1_item_q.a_valid <= in_i.a_valid;
      s1_item_q.b_byte  <= in_i.b_byte;
      s1_item_q.b_valid <= in_i.b_valid;
      s1_item_q.last    <= in_i.last;
    end
  end

  bscfd_cmp u_cmp (
    .item_i       (s1_item_q),
    .byte_index_i (byte_index_q),
    .step_o       (step)
  );

  // Fold this word into the comparison state
  always_comb begin
    idx_n = byte_index_q;
    dec_n = decided_q;
    ord_n = order_q;
    pos_n = pos_q;
    if (!decided_q) begin
      if (step.fix) begin
        dec_n = 1'b1;
        ord_n = step.order;
        pos_n = sat_pos(step.pos);
      end else begin
        if (byte_index_q < IdxCap) begin
          idx_n = byte_index_q + 1'b1;
        end
        if (s1_item_q.last) begin
          dec_n = 1'b1;
          ord_n = ORD_EQUAL;
          pos_n = sat_pos({1'b0, idx_n, 3'b000});
        end
      end
    end
  end

  // Rearm after last, else keep the folded state
  always_comb begin
    byte_index_d = byte_index_q;
    decided_d    = decided_q;
    order_d      = order_q;
    pos_d        = pos_q;
    if (fire) begin
      if (s1_item_q.last) begin
        byte_index_d = '0;
        decided_d    = 1'b0;
        order_d      = ORD_EQUAL;
        pos_d        = '0;
      end else begin
        byte_index_d = idx_n;
        decided_d    = dec_n;
        order_d      = ord_n;
        pos_d        = pos_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      decided_q    <= 1'b0;
      order_q      <= ORD_EQUAL;
      pos_q        <= '0;
    end else begin
      byte_index_q <= byte_index_d;
      decided_q    <= decided_d;
      order_q      <= order_d;
      pos_q        <= pos_d;
    end
  end

  bscfd_res_reg u_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_valid_q && s1_item_q.last),
    .order_i (ord_n),
    .pos_i   (pos_n),
    .space_o (adv),
    .out_o   (out_o)
  );

endmodule

// ===== hdl/bscfd_cmp.sv =====
// ----------------------------------------------------------------------------
// bscfd_cmp
// Compares one byte pair: finds the first differing valid bit, or the end
// of either string, and gives order and unsaturated position.
// ----------------------------------------------------------------------------
module bscfd_cmp
  import bscfd_pkg::*;
(
  input  item_t            item_i,
  input  logic [IdxW-1:0]  byte_index_i,
  output step_t            step_o
);

  logic [3:0]    av, bv, m;
  logic [7:0]    x;
  logic [3:0]    lz;
  logic [PosW:0] base;
  logic          abit;

  // Clamp counts and mask the common valid bits
  assign av = clamp8(item_i.a_valid);
  assign bv = clamp8(item_i.b_valid);
  assign m  = (av < bv) ? av : bv;
  assign x  = (item_i.a_byte ^ item_i.b_byte) & lead_mask(m);
  assign base = {1'b0, byte_index_i, 3'b000};

  // Leading zero count of the difference, 8 when none
  always_comb begin
    lz = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) begin
        lz = 4'(7 - i);
      end
    end
  end

  assign abit = (lz < 4'd8) ? item_i.a_byte[3'(7 - 32'(lz))] : 1'b0;

  // Pick the verdict for this pair
  always_comb begin
    step_o.fix   = 1'b1;
    step_o.order = ORD_EQUAL;
    step_o.pos   = base;
    if (x != 8'h00) begin
      step_o.order = abit ? ORD_GREATER : ORD_LESS;
      step_o.pos   = base + (PosW+1)'(lz);
    end else if (av != bv) begin
      step_o.order = (av < bv) ? ORD_LESS : ORD_GREATER;
      step_o.pos   = base + (PosW+1)'(m);
    end else if (av < 4'd8) begin
      step_o.pos   = base + (PosW+1)'(av);
    end else begin
      step_o.fix   = 1'b0;
    end
  end

endmodule

// ===== hdl/bscfd_res_reg.sv =====
// ----------------------------------------------------------------------------
// bscfd_res_reg
// Result register: holds one verdict word until the receiver takes it.
// ----------------------------------------------------------------------------
module bscfd_res_reg
  import bscfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  order_e           order_i,
  input  logic [PosW-1:0]  pos_i,
  output logic             space_o,
  bscfd_out_if.source      out_o
);

  logic            valid_q, valid_d;
  order_e          order_q;
  logic [PosW-1:0] pos_q;

  // Free when empty or when the held word leaves this cycle
  assign space_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = load_i;
    end
  end

  // Clear valid under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload
  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      order_q <= order_i;
      pos_q   <= pos_i;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.order    = order_q;
  assign out_o.diff_pos = pos_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit string first difference comparator. A
// short table of byte pairs covers the ends of every field, prefixes,
// strings that end together, pairs after the verdict and clamped counts.
// Random comparisons follow, with overlong streams and noise words mixed in.
// Every verdict word is checked against a behavioural model of the compare,
// or a typed table expectation, under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import bscfd_pkg::*;

  localparam int DirRows    = 22;
  localparam int PhaseWords = 342;
  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;

  typedef struct packed {
    order_e       order;
    logic [11:0]  pos;
  } verdict_t;

  typedef struct {
    logic [7:0] a;
    logic [3:0] av;
    logic [7:0] b;
    logic [3:0] bv;
    logic       last;
    bit         typed;
    order_e     ord;
    int         pos;
  } pair_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bscfd_in_if  in_if ();
  bscfd_out_if out_if ();

  bit_string_compare_first_difference dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Model state of the running comparison
  logic [IdxW-1:0] pair_count    = '0;
  bit              verdict_fixed = 1'b0;
  order_e          fixed_order   = ORD_EQUAL;
  logic [PosW-1:0] fixed_pos     = '0;

  verdict_t pending_verdicts[$];
  verdict_t head_v;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int words_counted  = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  // Directed byte pairs; typed expectations only where obvious
  pair_row_t dir_rows [DirRows] = '{
    '{8'hFF, 4'd8,  8'hFF, 4'd8, 1'b1, 1'b1, ORD_EQUAL,   8},
    '{8'h00, 4'd0,  8'h00, 4'd0, 1'b1, 1'b1, ORD_EQUAL,   0},
    '{8'h80, 4'd8,  8'h00, 4'd8, 1'b1, 1'b1, ORD_GREATER, 0},
    '{8'h00, 4'd8,  8'h01, 4'd8, 1'b1, 1'b1, ORD_LESS,    7},
    '{8'hAA, 4'd15, 8'hAA, 4'd9, 1'b1, 1'b1, ORD_EQUAL,   8},
    '{8'hA0, 4'd3,  8'hA0, 4'd8, 1'b1, 1'b1, ORD_LESS,    3},
    '{8'h5F, 4'd8,  8'h58, 4'd5, 1'b1, 1'b1, ORD_GREATER, 5},
    '{8'hC0, 4'd2,  8'hC0, 4'd2, 1'b1, 1'b1, ORD_EQUAL,   2},
    '{8'hFF, 4'd8,  8'hFF, 4'd8, 1'b0, 1'b0, ORD_EQUAL,   0},
    '{8'h00, 4'd0,  8'h12, 4'd8, 1'b1, 1'b1, ORD_LESS,    8},
    '{8'h3C, 4'd8,  8'h3D, 4'd8, 1'b0, 1'b0, ORD_EQUAL,   0},
    '{8'hFF, 4'd8,  8'h00, 4'd8, 1'b0, 1'b0, ORD_EQUAL,   0},
    '{8'h00, 4'd0,  8'h00, 4'd0, 1'b1, 1'b1, ORD_LESS,    7},
    '{8'h96, 4'd8,  8'h96, 4'd8, 1'b0, 1'b0, ORD_EQUAL,   0},
    '{8'h69, 4'd8,  8'h69, 4'd8, 1'b0, 1'b0, ORD_EQUAL,   0},
    '{8'hF0, 4'd8,  8'hF0, 4'd8, 1'b1, 1'b1, ORD_EQUAL,   24},
    '{8'h7E, 4'd8,  8'h7E, 4'd8, 1'b0, 1'b0, ORD_EQUAL,   0},
    '{8'h5A, 4'd6,  8'h5B, 4'd7, 1'b0, 1'b0, ORD_EQUAL,   0},
    '{8'hFF, 4'd8,  8'h00, 4'd8, 1'b1, 1'b0, ORD_EQUAL,   0},
    '{8'h0F, 4'd8,  8'h0F, 4'd0, 1'b1, 1'b1, ORD_GREATER, 0},
    '{8'hF3, 4'd4,  8'hFF, 4'd4, 1'b1, 1'b1, ORD_EQUAL,   4},
    '{8'h01, 4'd12, 8'hFE, 4'd8, 1'b1, 1'b1, ORD_LESS,    0}
  };

  // Fix the verdict, saturating the position
  task automatic fix_verdict(input order_e ord, input int pos);
    verdict_fixed = 1'b1;
    fixed_order   = ord;
    fixed_pos     = (pos > int'(PosCap)) ? PosCap : PosW'(pos);
  endtask

  // Fold one accepted byte pair into the comparison; queue a verdict on last
  task automatic fold_byte_pair(input item_t w, input bit typed, input verdict_t typed_v);
    logic [3:0] av;
    logic [3:0] bv;
    logic [3:0] m;
    logic [7:0] diff;
    int         lz;
    int         base;
    verdict_t   v;
    av   = (w.a_valid > 4'd8) ? 4'd8 : w.a_valid;
    bv   = (w.b_valid > 4'd8) ? 4'd8 : w.b_valid;
    if (!verdict_fixed) begin
      m    = (av < bv) ? av : bv;
      diff = (w.a_byte ^ w.b_byte) & ~(8'hFF >> m);
      base = int'(pair_count) * 8;
      if (diff != 8'h00) begin
        lz = 0;
        while (!diff[7 - lz]) lz++;
        fix_verdict(w.a_byte[7 - lz] ? ORD_GREATER : ORD_LESS, base + lz);
      end else if (av != bv) begin
        fix_verdict((av < bv) ? ORD_LESS : ORD_GREATER, base + int'(m));
      end else if (av < 4'd8) begin
        fix_verdict(ORD_EQUAL, base + int'(av));
      end else begin
        if (pair_count < IdxCap) pair_count++;
        if (w.last) fix_verdict(ORD_EQUAL, int'(pair_count) * 8);
      end
    end
    if (w.last) begin
      v.order = fixed_order;
      v.pos   = fixed_pos;
      pending_verdicts.push_back(typed ? typed_v : v);
      pair_count    = '0;
      verdict_fixed = 1'b0;
      fixed_order   = ORD_EQUAL;
      fixed_pos     = '0;
    end
  endtask

  // Offer one word, idling first at random; returns at the accepting edge
  task automatic send_word(input item_t w, input bit typed, input verdict_t typed_v);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.a_byte  <= w.a_byte;
    in_if.a_valid <= w.a_valid;
    in_if.b_byte  <= w.b_byte;
    in_if.b_valid <= w.b_valid;
    in_if.last    <= w.last;
    do begin
      @(negedge clk_i);
      taken = (in_if.ready === 1'b1);
      @(posedge clk_i);
    end while (!taken);
    fold_byte_pair(w, typed, typed_v);
    words_counted++;
  endtask

  // Drop valid and hold until every queued verdict has arrived
  task automatic drain_verdicts();
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // One comparison of n byte pairs, mostly well formed
  task automatic run_comparison(input int n, input int diff_pct);
    item_t    w;
    verdict_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      w.a_byte  = 8'($urandom_range(0, 255));
      w.b_byte  = w.a_byte;
      w.a_valid = 4'd8;
      w.b_valid = 4'd8;
      w.last    = 1'b0;
      if ($urandom_range(0, 99) < diff_pct)
        w.b_byte = w.a_byte ^ (8'h80 >> $urandom_range(0, 7));
      if (diff_pct != 0 && $urandom_range(0, 99) < 5) w.b_byte = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 10) w.a_valid = 4'($urandom_range(8, 15));
      if ($urandom_range(0, 99) < 10) w.b_valid = 4'($urandom_range(8, 15));
      // an early end leaves later pairs to be dropped
      if (diff_pct != 0 && $urandom_range(0, 99) < 3) w.a_valid = 4'($urandom_range(0, 7));
      if (i == n - 1) begin
        w.last = 1'b1;
        case ($urandom_range(0, 3))
          0: ;
          1: begin
            w.a_valid = 4'($urandom_range(0, 7));
            w.b_valid = w.a_valid;
          end
          2: begin
            w.a_valid = 4'($urandom_range(0, 15));
            w.b_valid = 4'($urandom_range(0, 15));
          end
          default: begin
            if ($urandom_range(0, 1) != 0) w.a_valid = 4'd0;
            else w.b_valid = 4'd0;
          end
        endcase
      end
      send_word(w, 1'b0, none);
    end
  endtask

  // Receiver: long hold-off on request, otherwise random stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Check each verdict word against the oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: verdict with none expected, order=%0d diff_pos=%0d",
                   out_if.order, out_if.diff_pos);
      end else begin
        head_v = pending_verdicts.pop_front();
        if (out_if.order !== head_v.order || out_if.diff_pos !== head_v.pos) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected order=%0d diff_pos=%0d, got order=%0d diff_pos=%0d",
                     head_v.order, head_v.pos, out_if.order, out_if.diff_pos);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[bit_string_compare_first_difference] ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    item_t    w;
    verdict_t tv;
    int       target;
    int       send_mix [4];
    int       recv_mix [4];
    send_mix = '{0, 67, 0, 25};
    recv_mix = '{0, 0, 67, 25};
    in_if.valid   = 1'b0;
    in_if.a_byte  = '0;
    in_if.a_valid = '0;
    in_if.b_byte  = '0;
    in_if.b_valid = '0;
    in_if.last    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[r]) begin
      w.a_byte  = dir_rows[r].a;
      w.a_valid = dir_rows[r].av;
      w.b_byte  = dir_rows[r].b;
      w.b_valid = dir_rows[r].bv;
      w.last    = dir_rows[r].last;
      tv.order  = dir_rows[r].ord;
      tv.pos    = 12'(dir_rows[r].pos);
      send_word(w, dir_rows[r].typed, tv);
    end
    drain_verdicts();

    // Random phases, each closed by a full drain
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct   = send_mix[ph];
      recv_stall_pct <= recv_mix[ph];
      if (ph == 0) begin
        hold_requests <= hold_requests + 1;
        // overlong streams run into the byte and position bounds
        run_comparison(300, 0);
        run_comparison(258, 0);
      end
      target = words_counted + PhaseWords;
      while (words_counted < target) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            w.a_byte  = 8'($urandom_range(0, 255));
            w.a_valid = 4'($urandom_range(0, 15));
            w.b_byte  = 8'($urandom_range(0, 255));
            w.b_valid = 4'($urandom_range(0, 15));
            w.last    = ($urandom_range(0, 99) < 30);
            send_word(w, 1'b0, '0);
          end
        end else begin
          run_comparison(($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(1, 6), 8);
        end
      end
      drain_verdicts();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("[bit_string_compare_first_difference] OK");
    end else begin
      $display("[bit_string_compare_first_difference] ERROR");
    end
    $finish;
  end

endmodule
